// ----- hdl/fbma_pkg.sv -----
`default_nettype none
package fbma_pkg;

	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DELETE  = 2'd1;
	localparam logic [1:0] CMD_LIST    = 2'd2;
	localparam logic [1:0] CMD_RESOLVE = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SPACE    = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_NOINODE  = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] name_low;
		logic [63:0] name_high;
		logic [3:0]  block_count;
		logic [3:0]  block_index;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  inode_number;
		logic [63:0] out_name_low;
		logic [63:0] out_name_high;
		logic [3:0]  file_blocks;
		logic [6:0]  disk_block;
		logic        last;
	} res_word_t;

endpackage
`default_nettype wire

// ----- hdl/file_block_map_allocator.sv -----
// Channel  | Ports                    | Handshake
// command  | start, busy, cmd_in      | taken when start && !busy
// result   | res_valid, res           | one-cycle strobe per word, no stall
// Run time is set by the one-entry-per-cycle walk of the block map and by the
// registered read of each inode and pointer RAM entry: create walks the block
// map, delete, resolve and list walk the inodes, and delete then walks the
// pointers of the file it frees.
// Reset clears the valid bits of inodes and blocks at once; no sweep.
// Busy stays high from acceptance until the last word has gone.
`default_nettype none
module file_block_map_allocator #(
	parameter int NUM_BLOCKS      = 128,
	parameter int NUM_INODES      = 16,
	parameter int BLOCKS_PER_FILE = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire fbma_pkg::cmd_word_t cmd_in,
	output logic                 busy,
	output logic                 res_valid,
	output fbma_pkg::res_word_t  res
);
	localparam int BW  = $clog2(NUM_BLOCKS);
	localparam int IW  = (NUM_INODES > 1) ? $clog2(NUM_INODES) : 1;
	localparam int PW  = (BLOCKS_PER_FILE > 1) ? $clog2(BLOCKS_PER_FILE) : 1;
	localparam int PD  = NUM_INODES * BLOCKS_PER_FILE;
	localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
	localparam int ND  = (NUM_INODES > 1) ? NUM_INODES : 2;
	localparam int PDD = (PD > 1) ? PD : 2;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_COUNT = 4'd1;
	localparam logic [3:0] S_ALLOC = 4'd2;
	localparam logic [3:0] S_ALCHK = 4'd3;
	localparam logic [3:0] S_FIND  = 4'd4;
	localparam logic [3:0] S_FCHK  = 4'd5;
	localparam logic [3:0] S_FREE  = 4'd6;
	localparam logic [3:0] S_FRCHK = 4'd7;
	localparam logic [3:0] S_RES   = 4'd8;
	localparam logic [3:0] S_LIST  = 4'd9;
	localparam logic [3:0] S_LCHK  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0] state_q;
	fbma_pkg::cmd_word_t c_q;
	logic [NUM_BLOCKS-1:0] blk_q;
	logic [NUM_INODES-1:0] used_q;
	logic [BW:0] cnt_q;
	logic [BW:0] free_q;
	logic [IW:0] ino_q;
	logic [IW-1:0] node_q;
	logic [4:0] taken_q;
	logic any_q;

	// inode name/size RAM and block pointer RAM
	logic          n_we;
	logic [IW-1:0] n_waddr, n_raddr;
	logic [131:0]  n_wdata, n_rdata;
	logic          p_we;
	logic [PAW-1:0] p_waddr, p_raddr;
	logic [6:0]    p_wdata, p_rdata;

	fbma_ram #(.WIDTH(132), .DEPTH(ND)) u_nram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rdata)
	);
	fbma_ram #(.WIDTH(7), .DEPTH(PDD)) u_pram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	logic first_free_ok;
	logic [IW-1:0] first_free;
	always_comb begin
		first_free_ok = 1'b0;
		first_free = '0;
		for (int i = NUM_INODES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				first_free_ok = 1'b1;
				first_free = IW'(i);
			end
		end
	end

	logic [IW-1:0] ino_ix;
	assign ino_ix = ino_q[IW-1:0];
	logic [BW-1:0] cnt_ix;
	assign cnt_ix = cnt_q[BW-1:0];
	logic name_hit;
	assign name_hit = (n_rdata[131:68] == c_q.name_low) && (n_rdata[67:4] == c_q.name_high);

	assign busy = (state_q != S_IDLE);
	assign n_raddr = ino_ix;
	assign n_waddr = first_free;
	assign n_wdata = {c_q.name_low, c_q.name_high, c_q.block_count};
	assign n_we = (state_q == S_COUNT) && (cnt_q == (BW+1)'(NUM_BLOCKS))
		&& ({1'b0, c_q.block_count} <= 5'(BLOCKS_PER_FILE))
		&& (free_q >= (BW+1)'(c_q.block_count)) && first_free_ok;
	assign p_waddr = PAW'(node_q * BLOCKS_PER_FILE + PW'(taken_q));
	assign p_wdata = 7'(cnt_ix);
	assign p_we = (state_q == S_ALLOC) && !blk_q[cnt_ix] && (taken_q < 5'(c_q.block_count));

	always_comb begin
		if (state_q == S_RES) p_raddr = PAW'(node_q * BLOCKS_PER_FILE + PW'(c_q.block_index));
		else p_raddr = PAW'(node_q * BLOCKS_PER_FILE + PW'(taken_q));
	end

	task automatic emit(input logic [2:0] st, input logic [3:0] ino, input logic [6:0] db);
		res_valid <= 1'b1;
		res.status <= st;
		res.inode_number <= ino;
		res.out_name_low <= '0;
		res.out_name_high <= '0;
		res.file_blocks <= '0;
		res.disk_block <= db;
		res.last <= 1'b1;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			blk_q <= '0;
			used_q <= '0;
			res_valid <= 1'b0;
			res <= '0;
			cnt_q <= '0;
			free_q <= '0;
			ino_q <= '0;
			node_q <= '0;
			taken_q <= '0;
			any_q <= 1'b0;
			c_q <= '0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						c_q <= cmd_in;
						cnt_q <= '0;
						free_q <= '0;
						ino_q <= '0;
						taken_q <= '0;
						any_q <= 1'b0;
						case (cmd_in.cmd)
							fbma_pkg::CMD_CREATE: state_q <= S_COUNT;
							fbma_pkg::CMD_LIST:   state_q <= S_LIST;
							default:              state_q <= S_FIND;
						endcase
					end
				end
				S_COUNT: begin
					if (cnt_q == (BW+1)'(NUM_BLOCKS)) begin
						cnt_q <= '0;
						if ({1'b0, c_q.block_count} > 5'(BLOCKS_PER_FILE)
								|| free_q < (BW+1)'(c_q.block_count)) begin
							emit(fbma_pkg::ST_SPACE, 4'd0, 7'd0);
							state_q <= S_DONE;
						end else if (!first_free_ok) begin
							emit(fbma_pkg::ST_NOINODE, 4'd0, 7'd0);
							state_q <= S_DONE;
						end else begin
							used_q[first_free] <= 1'b1;
							node_q <= first_free;
							state_q <= S_ALLOC;
						end
					end else begin
						if (!blk_q[cnt_ix]) free_q <= free_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ALLOC: begin
					if (taken_q == 5'(c_q.block_count) || cnt_q == (BW+1)'(NUM_BLOCKS)) begin
						emit(fbma_pkg::ST_OK, 4'(node_q), 7'd0);
						state_q <= S_DONE;
					end else begin
						if (p_we) begin
							blk_q[cnt_ix] <= 1'b1;
							taken_q <= taken_q + 1'b1;
						end
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIND: begin
					if (ino_q == (IW+1)'(NUM_INODES)) begin
						emit(fbma_pkg::ST_NOTFOUND, 4'd0, 7'd0);
						state_q <= S_DONE;
					end else state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (used_q[ino_ix] && name_hit) begin
						node_q <= ino_ix;
						free_q <= (BW+1)'(n_rdata[3:0]);
						if (c_q.cmd == fbma_pkg::CMD_DELETE) begin
							used_q[ino_ix] <= 1'b0;
							state_q <= S_FREE;
						end else if (c_q.block_index >= n_rdata[3:0]
								|| {1'b0, c_q.block_index} >= 5'(BLOCKS_PER_FILE)) begin
							emit(fbma_pkg::ST_RANGE, 4'(ino_ix), 7'd0);
							state_q <= S_DONE;
						end else state_q <= S_RES;
					end else begin
						ino_q <= ino_q + 1'b1;
						state_q <= S_FIND;
					end
				end
				S_RES: state_q <= S_ALCHK;
				S_ALCHK: begin
					emit(fbma_pkg::ST_OK, 4'(node_q), p_rdata);
					state_q <= S_DONE;
				end
				S_FREE: begin
					if (5'(taken_q) >= 5'(free_q) || taken_q >= 5'(BLOCKS_PER_FILE)) begin
						emit(fbma_pkg::ST_OK, 4'(node_q), 7'd0);
						state_q <= S_DONE;
					end else state_q <= S_FRCHK;
				end
				S_FRCHK: begin
					if ({1'b0, p_rdata} < 8'(NUM_BLOCKS)) blk_q[BW'(p_rdata)] <= 1'b0;
					taken_q <= taken_q + 1'b1;
					state_q <= S_FREE;
				end
				S_LIST: begin
					if (ino_q == (IW+1)'(NUM_INODES)) begin
						if (!any_q) emit(fbma_pkg::ST_NOTFOUND, 4'd0, 7'd0);
						state_q <= S_DONE;
					end else state_q <= S_LCHK;
				end
				S_LCHK: begin
					if (used_q[ino_ix]) begin
						res_valid <= 1'b1;
						res.status <= fbma_pkg::ST_OK;
						res.inode_number <= 4'(ino_ix);
						res.out_name_low <= n_rdata[131:68];
						res.out_name_high <= n_rdata[67:4];
						res.file_blocks <= n_rdata[3:0];
						res.disk_block <= '0;
						res.last <= ((used_q >> ino_ix) >> 1) == '0;
						any_q <= 1'b1;
					end
					ino_q <= ino_q + 1'b1;
					state_q <= S_LIST;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !res_valid) else $error("strobe while idle");
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("command not taken");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last) |-> ((state_q == S_DONE) || (state_q == S_LIST)))
		else $error("last word early");
`endif
endmodule
`default_nettype wire

// ----- hdl/fbma_ram.sv -----
`default_nettype none
module fbma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
